// ----- rtl/svr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package svr_pkg;

  typedef logic [7:0] byte_t;

  // Longest key the history can hold; a longer key never matches.
  localparam int LONGEST_KEY = 14;
  localparam int HIST_DEPTH  = LONGEST_KEY + 1;

  localparam int NUM_KEYS = 10;
  localparam int KEY_MAX  = 14;
  localparam int KEY_W    = (LONGEST_KEY > KEY_MAX) ? LONGEST_KEY : KEY_MAX;

  // Keys are right-justified, so the last character of a key sits in bits [7:0].
  localparam logic [8*KEY_W-1:0] KEY_STR [NUM_KEYS] = '{
    (8*KEY_W)'("password"),
    (8*KEY_W)'("passwd"),
    (8*KEY_W)'("secret"),
    (8*KEY_W)'("token"),
    (8*KEY_W)'({"private", "_key"}),
    (8*KEY_W)'("credential"),
    (8*KEY_W)'("verifier"),
    (8*KEY_W)'({"encryption", "_key"}),
    (8*KEY_W)'({"decryption", "_key"}),
    (8*KEY_W)'({"key", "_handle"})
  };

  localparam int KEY_LEN [NUM_KEYS] = '{8, 6, 6, 5, 11, 10, 8, 14, 14, 10};

  localparam int          MARK_LEN  = 10;
  localparam logic [79:0] MARK_STR  = "[redacted]";

  typedef logic [3:0] mark_idx_t;
  localparam mark_idx_t MARK_LAST = mark_idx_t'(MARK_LEN - 1);

  localparam byte_t CH_EQUAL = 8'h3d;
  localparam byte_t CH_COLON = 8'h3a;

  // What a history cell shows to the key matcher.
  typedef struct packed {
    byte_t low;
    logic  word;
    logic  vld;
  } cell_view_t;

  // One result item.
  typedef struct packed {
    byte_t data;
    logic  has;
    logic  done;
    logic  last;
  } res_t;

  function automatic byte_t lower_ascii(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic word_byte(input byte_t c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5f || c == 8'h2d;
  endfunction

  function automatic logic delim_byte(input byte_t c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0d ||
           c == 8'h2c || c == 8'h3b || c == 8'h26 || c == 8'h22 || c == 8'h27;
  endfunction

  function automatic byte_t mark_byte(input mark_idx_t idx);
    byte_t r;
    r = '0;
    for (int j = 0; j < MARK_LEN; j++) begin
      if (idx == mark_idx_t'(j)) begin
        r = MARK_STR[8*(MARK_LEN-1-j) +: 8];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/svr_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One byte of emitted history; shifts to its older neighbor whenever shift is set.
module svr_cell import svr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       shift,
  input  wire logic       clear,
  input  wire byte_t      din,
  input  wire logic       vin,
  output byte_t           dout,
  output logic            vout,
  output cell_view_t      view
);

  byte_t data;
  logic  vld;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= 1'b0;
    end else if (shift) begin
      vld <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= din;
    end
  end

  assign dout      = data;
  assign vout      = vld;
  assign view.low  = lower_ascii(data);
  assign view.word = word_byte(data);
  assign view.vld  = vld;

endmodule

`default_nettype wire

// ----- rtl/svr_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Compares the history row against every key at once; hit means a key ends
// right before the incoming byte and stands on a word boundary.
module svr_match import svr_pkg::*; (
  input  wire cell_view_t view [HIST_DEPTH],
  output logic            hit
);

  always_comb begin
    logic ok;
    hit = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ok = 1'b1;
      if (KEY_LEN[k] > LONGEST_KEY) begin
        ok = 1'b0;
      end else begin
        for (int i = 0; i < LONGEST_KEY; i++) begin
          if (i < KEY_LEN[k]) begin
            if (!view[i].vld || view[i].low != KEY_STR[k][8*i +: 8]) begin
              ok = 1'b0;
            end
          end
        end
        for (int j = 1; j < HIST_DEPTH; j++) begin
          if (j == KEY_LEN[k] && view[j].vld && view[j].word) begin
            ok = 1'b0;
          end
        end
      end
      hit = hit | ok;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/svr_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result queue: the output register plus one skid slot.
module svr_outq import svr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire res_t din,
  output logic      full,
  output logic      valid,
  input  wire logic ready,
  output res_t      dout
);

  res_t       slot0;
  res_t       slot1;
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       pop;

  assign pop   = valid && ready;
  assign valid = cnt != 2'd0;
  assign full  = cnt == 2'd2;
  assign dout  = slot0;

  always_comb begin
    cnt_next = cnt;
    case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt == 2'd2) begin
        slot0 <= slot1;
        if (push) begin
          slot1 <= din;
        end
      end else if (push) begin
        slot0 <= din;
      end
    end else if (push) begin
      if (cnt == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/secret_value_redactor.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_ready  text_byte, end_of_text
// output    out_valid/out_ready  out_byte, has_byte, text_done, last_of_run
//
// One input item is taken per cycle while the output side keeps up; an item
// that causes no result (a dropped byte) is taken the same way.
// After a matched key the "[redacted]" bytes go out one per cycle while the
// queue has room, via the single history push port; input is held off meanwhile.
// Reset (rst, synchronous) empties the history, the result queue and all flags.
// A two-entry result queue lets a new item enter while one result waits.
module secret_value_redactor import svr_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire byte_t text_byte,
  input  wire logic  end_of_text,
  output logic       out_valid,
  input  wire logic  out_ready,
  output byte_t      out_byte,
  output logic       has_byte,
  output logic       text_done,
  output logic       last_of_run
);

  // History chain: cell 0 holds the newest emitted byte.
  byte_t      cell_data [HIST_DEPTH];
  logic       cell_vld  [HIST_DEPTH];
  cell_view_t cell_view [HIST_DEPTH];

  logic      shift;
  logic      clear;
  byte_t     hist_in;
  logic      hit;

  // Sequencer state for the inserted marker and for value dropping.
  logic      ins_active;
  logic      ins_active_next;
  mark_idx_t ins_idx;
  mark_idx_t ins_idx_next;
  logic      ins_eot;
  logic      ins_eot_next;
  logic      supp;
  logic      supp_next;

  logic      q_full;
  logic      push;
  res_t      res;
  res_t      q_out;
  logic      accept;
  logic      take_key;

  for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      svr_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .clear(clear),
        .din  (hist_in),
        .vin  (1'b1),
        .dout (cell_data[g]),
        .vout (cell_vld[g]),
        .view (cell_view[g])
      );
    end else begin : g_body
      svr_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .shift(shift),
        .clear(clear),
        .din  (cell_data[g-1]),
        .vin  (cell_vld[g-1]),
        .dout (cell_data[g]),
        .vout (cell_vld[g]),
        .view (cell_view[g])
      );
    end
  end

  svr_match u_match (
    .view(cell_view),
    .hit (hit)
  );

  svr_outq u_outq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (res),
    .full (q_full),
    .valid(out_valid),
    .ready(out_ready),
    .dout (q_out)
  );

  assign out_byte    = q_out.data;
  assign has_byte    = q_out.has;
  assign text_done   = q_out.done;
  assign last_of_run = q_out.last;

  // While the marker is being issued no input is taken.
  assign in_ready = !ins_active && !q_full;
  assign accept   = in_valid && in_ready;

  // A separator outside a value whose preceding bytes spell a key.
  assign take_key = !supp && (text_byte == CH_EQUAL || text_byte == CH_COLON) && hit;

  always_comb begin
    push            = 1'b0;
    res             = '0;
    shift           = 1'b0;
    clear           = 1'b0;
    hist_in         = text_byte;
    ins_active_next = ins_active;
    ins_idx_next    = ins_idx;
    ins_eot_next    = ins_eot;
    supp_next       = supp;

    if (ins_active) begin
      // Issue one marker byte per cycle while the queue is not full; the bytes also enter the history.
      if (!q_full) begin
        push     = 1'b1;
        res.data = mark_byte(ins_idx);
        res.has  = 1'b1;
        shift    = 1'b1;
        hist_in  = res.data;
        if (ins_idx == MARK_LAST) begin
          res.last        = 1'b1;
          res.done        = ins_eot;
          ins_active_next = 1'b0;
          supp_next       = 1'b1;
          if (ins_eot) begin
            // The text ended on the separator: the value is empty.
            clear     = 1'b1;
            supp_next = 1'b0;
          end
        end else begin
          ins_idx_next = ins_idx + mark_idx_t'(1);
        end
      end
    end else if (accept) begin
      if (supp) begin
        if (delim_byte(text_byte)) begin
          push      = 1'b1;
          res.data  = text_byte;
          res.has   = 1'b1;
          res.last  = 1'b1;
          res.done  = end_of_text;
          shift     = 1'b1;
          supp_next = 1'b0;
        end else if (end_of_text) begin
          // The last byte was dropped: send a bare end marker.
          push     = 1'b1;
          res.done = 1'b1;
          res.last = 1'b1;
        end
      end else if (take_key) begin
        push            = 1'b1;
        res.data        = text_byte;
        res.has         = 1'b1;
        shift           = 1'b1;
        ins_active_next = 1'b1;
        ins_idx_next    = '0;
        ins_eot_next    = end_of_text;
      end else begin
        push     = 1'b1;
        res.data = text_byte;
        res.has  = 1'b1;
        res.last = 1'b1;
        res.done = end_of_text;
        shift    = 1'b1;
      end
      // End of text empties the history and ends value dropping, unless the marker
      // still has to go out; then the last marker byte does it.
      if (end_of_text && !take_key) begin
        clear     = 1'b1;
        supp_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ins_active <= 1'b0;
      ins_idx    <= '0;
      ins_eot    <= 1'b0;
      supp       <= 1'b0;
    end else begin
      ins_active <= ins_active_next;
      ins_idx    <= ins_idx_next;
      ins_eot    <= ins_eot_next;
      supp       <= supp_next;
    end
  end

endmodule

`default_nettype wire
